FILE: sv/pcc_pkg.sv
package pcc_pkg;

  // One input pixel and one corrected pixel, 8 bits per channel
  typedef struct packed {
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
  } pix_out_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_GAIN         = 3'd0,
    REG_BLACK_OFFSET = 3'd1,
    REG_GAMMA_WEIGHT = 3'd2,
    REG_CHROMA_COS   = 3'd3,
    REG_CHROMA_SIN   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic        [15:0] gain;
    logic signed [10:0] black_offset;
    logic        [12:0] gamma_weight;
    logic signed [15:0] chroma_cos;
    logic signed [15:0] chroma_sin;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    gain:         16'd4096,
    black_offset: 11'sd0,
    gamma_weight: 13'd0,
    chroma_cos:   16'sd8192,
    chroma_sin:   16'sd0
  };

  // Channel value after the front end, Q.6
  localparam int FE_W = 26;
  // Corrected channel before the final rounding, Q.6
  localparam int OUT_W = 32;

  // Pipeline depths: front end, colour space section, output register
  localparam int FE_LAT  = 6;
  localparam int CS_LAT  = 9;
  localparam int LATENCY = FE_LAT + CS_LAT + 1;

  // Colour matrix, Q4.12
  localparam logic signed [12:0] Y_R  = 13'sd1225;
  localparam logic signed [12:0] Y_G  = 13'sd2404;
  localparam logic signed [12:0] Y_B  = 13'sd467;
  localparam logic signed [12:0] U_K  = 13'sd2015;
  localparam logic signed [12:0] V_K  = 13'sd3592;
  localparam logic signed [14:0] B_U  = 15'sd8323;
  localparam logic signed [12:0] G_U  = 13'sd1618;
  localparam logic signed [12:0] G_V  = 13'sd2380;
  localparam logic signed [13:0] R_V  = 14'sd4669;

  // Round half up from Q.6 and clamp to a byte
  function automatic logic [7:0] sat_byte(input logic signed [OUT_W-1:0] v);
    logic signed [OUT_W-1:0] r;
    r = (v + OUT_W'(32)) >>> 6;
    if (r < 0) begin
      sat_byte = 8'd0;
    end else if (r > OUT_W'(255)) begin
      sat_byte = 8'd255;
    end else begin
      sat_byte = r[7:0];
    end
  endfunction

endpackage

FILE: sv/pcc_front_end.sv
module pcc_front_end (
  input  logic                            clk,
  input  logic [7:0]                      x,
  input  pcc_pkg::cfg_t                   cfg,
  output logic signed [pcc_pkg::FE_W-1:0] fe
);

  logic        [23:0] xg;
  logic        [23:0] xg_rnd;
  logic signed [19:0] a2;
  logic signed [19:0] a3;
  logic signed [19:0] a4;
  logic        [18:0] mag;
  logic        [37:0] sq;
  logic        [49:0] sqk;
  logic        [23:0] q;
  logic signed [13:0] wg;
  logic signed [33:0] m1;
  logic        [36:0] m2;
  logic signed [37:0] s;

  // stage 1: gain
  always_ff @(posedge clk) begin
    xg <= 24'(x) * 24'(cfg.gain);
  end

  // stage 2: back to Q.6 and add black level
  always_comb xg_rnd = xg + 24'd32;

  always_ff @(posedge clk) begin
    a2 <= $signed({2'b00, xg_rnd[23:6]})
        + $signed({{3{cfg.black_offset[10]}}, cfg.black_offset, 6'b0});
  end

  // stage 3: square of the magnitude, Q.12
  always_comb mag = a2[19] ? 19'(-a2) : 19'(a2);

  always_ff @(posedge clk) begin
    sq <= 38'(mag) * 38'(mag);
    a3 <= a2;
  end

  // stage 4: times 0.0039 (4089 in Q0.20 = 4096 - 8 + 1), back to Q.6
  always_comb sqk = (50'(sq) << 12) - (50'(sq) << 3) + 50'(sq) + (50'd1 << 25);

  always_ff @(posedge clk) begin
    q  <= sqk[49:26];
    a4 <= a3;
  end

  // stage 5: blend weights
  always_comb wg = 14'sd4096 - $signed({1'b0, cfg.gamma_weight});

  always_ff @(posedge clk) begin
    m1 <= 34'(a4) * 34'(wg);
    m2 <= 37'(q) * 37'(cfg.gamma_weight);
  end

  // stage 6: blend sum, rounded back to Q.6
  always_comb s = 38'(m1) + $signed({1'b0, m2}) + 38'sd2048;

  always_ff @(posedge clk) begin
    fe <= s[37:12];
  end

endmodule

FILE: sv/pcc_color_space.sv
module pcc_color_space (
  input  logic                             clk,
  input  pcc_pkg::cfg_t                    cfg,
  input  logic signed [pcc_pkg::FE_W-1:0]  fe_b,
  input  logic signed [pcc_pkg::FE_W-1:0]  fe_g,
  input  logic signed [pcc_pkg::FE_W-1:0]  fe_r,
  output logic signed [pcc_pkg::OUT_W-1:0] bo,
  output logic signed [pcc_pkg::OUT_W-1:0] go,
  output logic signed [pcc_pkg::OUT_W-1:0] ro
);

  logic signed [38:0] py_r, py_g, py_b;
  logic signed [38:0] ysum;
  logic signed [pcc_pkg::FE_W-1:0] b7, r7, b8, r8;
  logic signed [pcc_pkg::FE_W-1:0] y8, y9, y10, y11, y12, y13, y14;
  logic signed [26:0] db, dr;
  logic signed [39:0] pu, pv;
  logic signed [39:0] urnd, vrnd;
  logic signed [25:0] u, v;
  logic signed [41:0] uc, vs, vc, us;
  logic signed [42:0] u2sum, v2sum;
  logic signed [30:0] u2, v2;
  logic signed [45:0] pb, pg1, pg2, pr;
  logic signed [45:0] bsum, rsum;
  logic signed [46:0] gsum;

  // stage 1: luma products
  always_ff @(posedge clk) begin
    py_r <= 39'(fe_r) * 39'(pcc_pkg::Y_R);
    py_g <= 39'(fe_g) * 39'(pcc_pkg::Y_G);
    py_b <= 39'(fe_b) * 39'(pcc_pkg::Y_B);
    b7   <= fe_b;
    r7   <= fe_r;
  end

  // stage 2: luma
  always_comb ysum = py_r + py_g + py_b + 39'sd2048;

  always_ff @(posedge clk) begin
    y8 <= ysum[37:12];
    b8 <= b7;
    r8 <= r7;
  end

  // stage 3: colour differences
  always_ff @(posedge clk) begin
    db <= 27'(b8) - 27'(y8);
    dr <= 27'(r8) - 27'(y8);
    y9 <= y8;
  end

  // stage 4: chroma scaling
  always_ff @(posedge clk) begin
    pu  <= 40'(db) * 40'(pcc_pkg::U_K);
    pv  <= 40'(dr) * 40'(pcc_pkg::V_K);
    y10 <= y9;
  end

  // stage 5: U and V
  always_comb begin
    urnd = pu + 40'sd2048;
    vrnd = pv + 40'sd2048;
  end

  always_ff @(posedge clk) begin
    u   <= urnd[37:12];
    v   <= vrnd[37:12];
    y11 <= y10;
  end

  // stage 6: hue rotation products
  always_ff @(posedge clk) begin
    uc  <= 42'(u) * 42'(cfg.chroma_cos);
    vs  <= 42'(v) * 42'(cfg.chroma_sin);
    vc  <= 42'(v) * 42'(cfg.chroma_cos);
    us  <= 42'(u) * 42'(cfg.chroma_sin);
    y12 <= y11;
  end

  // stage 7: rotated chroma
  always_comb begin
    u2sum = 43'(uc) + 43'(vs) + 43'sd2048;
    v2sum = 43'(vc) - 43'(us) + 43'sd2048;
  end

  always_ff @(posedge clk) begin
    u2  <= u2sum[42:12];
    v2  <= v2sum[42:12];
    y13 <= y12;
  end

  // stage 8: inverse matrix products
  always_ff @(posedge clk) begin
    pb  <= 46'(u2) * 46'(pcc_pkg::B_U);
    pg1 <= 46'(u2) * 46'(pcc_pkg::G_U);
    pg2 <= 46'(v2) * 46'(pcc_pkg::G_V);
    pr  <= 46'(v2) * 46'(pcc_pkg::R_V);
    y14 <= y13;
  end

  // stage 9: back to B, G, R in Q.6
  always_comb begin
    bsum = pb + 46'sd2048;
    gsum = 47'(pg1) + 47'(pg2) + 47'sd2048;
    rsum = pr + 46'sd2048;
  end

  always_ff @(posedge clk) begin
    bo <= pcc_pkg::OUT_W'(y14) + pcc_pkg::OUT_W'(bsum >>> 12);
    go <= pcc_pkg::OUT_W'(y14) - pcc_pkg::OUT_W'(gsum >>> 12);
    ro <= pcc_pkg::OUT_W'(y14) + pcc_pkg::OUT_W'(rsum >>> 12);
  end

endmodule

FILE: sv/pixel_color_correction.sv
// Pixel colour correction: gain, black level, gamma blend, hue and saturation on
// 8-bit BGR. A pixel is taken on every clock where start is high (busy stays low),
// so a full pixel stream runs at one pixel per clock. The corrected pixel appears
// on result with result_valid high for a single cycle once the pixel has passed
// the six-stage front end (gain, black level, square, blend), the nine colour
// space stages and the output register. There is no backpressure:
// the receiver must take every word as it appears. Registers are written through
// the cfg port (always ready) and should only change while no pixel is in flight.
module pixel_color_correction (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  pcc_pkg::pix_in_t  pixel,
  output pcc_pkg::pix_out_t result,
  output logic              result_valid,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  pcc_pkg::cfg_t cfg;
  logic [pcc_pkg::LATENCY-1:0] vld;
  logic signed [pcc_pkg::FE_W-1:0]  fe_b, fe_g, fe_r;
  logic signed [pcc_pkg::OUT_W-1:0] bo, go, ro;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= pcc_pkg::CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (pcc_pkg::reg_idx_t'(cfg_index))
        pcc_pkg::REG_GAIN:         cfg.gain         <= cfg_data;
        pcc_pkg::REG_BLACK_OFFSET: cfg.black_offset <= cfg_data[10:0];
        pcc_pkg::REG_GAMMA_WEIGHT: cfg.gamma_weight <= cfg_data[12:0];
        pcc_pkg::REG_CHROMA_COS:   cfg.chroma_cos   <= cfg_data;
        pcc_pkg::REG_CHROMA_SIN:   cfg.chroma_sin   <= cfg_data;
        default: ;
      endcase
    end
  end

  // valid bits follow each word down the pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[pcc_pkg::LATENCY-2:0], start && !busy};
    end
  end

  assign result_valid = vld[pcc_pkg::LATENCY-1];

  // per-channel gain, offset and gamma
  pcc_front_end u_fe_b (.clk(clk), .x(pixel.blue_in),  .cfg(cfg), .fe(fe_b));
  pcc_front_end u_fe_g (.clk(clk), .x(pixel.green_in), .cfg(cfg), .fe(fe_g));
  pcc_front_end u_fe_r (.clk(clk), .x(pixel.red_in),   .cfg(cfg), .fe(fe_r));

  // YUV, hue rotation and back
  pcc_color_space u_cs (
    .clk  (clk),
    .cfg  (cfg),
    .fe_b (fe_b),
    .fe_g (fe_g),
    .fe_r (fe_r),
    .bo   (bo),
    .go   (go),
    .ro   (ro)
  );

  // output register: round and clamp
  always_ff @(posedge clk) begin
    result.blue_out  <= pcc_pkg::sat_byte(bo);
    result.green_out <= pcc_pkg::sat_byte(go);
    result.red_out   <= pcc_pkg::sat_byte(ro);
  end

endmodule

FILE: sv/pcc_checker.sv
module pcc_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic result_valid
);

  // every accepted pixel comes out after the fixed pipeline depth
  a_word_out: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(pcc_pkg::LATENCY) result_valid)
    else $error("accepted pixel produced no result");

  // no result without a pixel taken the pipeline depth earlier
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start && !busy, pcc_pkg::LATENCY))
    else $error("result without matching input");

  // reset flushes the pipe
  a_reset_flush: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result straight after reset");

endmodule

bind pixel_color_correction pcc_checker u_pcc_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid)
);

FILE: test/testbench.sv
module testbench;

  // Predictor constants: Q4.12 colour matrix and the gamma factor in Q0.20
  localparam longint LUMA_R   = 1225;
  localparam longint LUMA_G   = 2404;
  localparam longint LUMA_B   = 467;
  localparam longint CB_SCALE = 2015;
  localparam longint CR_SCALE = 3592;
  localparam longint B_OF_CB  = 8323;
  localparam longint G_OF_CB  = 1618;
  localparam longint G_OF_CR  = 2380;
  localparam longint R_OF_CR  = 4669;
  localparam longint GAMMA_Q20 = 4089;
  localparam int     COEF_FRAC = 12;
  localparam int     PIX_FRAC  = 6;

  // Register indexes past the end of the map; writes there must be dropped
  localparam logic [2:0] IDX_SPARE_LO = 3'd5;
  localparam logic [2:0] IDX_SPARE_HI = 3'd7;

  localparam int RAND_PHASES   = 10;
  localparam int PIX_PER_PHASE = 200;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  pcc_pkg::pix_in_t  pixel;
  pcc_pkg::pix_out_t result;
  logic     result_valid;
  logic     cfg_valid;
  logic     cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  pixel_color_correction dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .pixel        (pixel),
    .result       (result),
    .result_valid (result_valid),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Shadow copy of the register file, and the corrected pixels still owed
  pcc_pkg::cfg_t     cfg_shadow;
  pcc_pkg::pix_out_t corrected_q[$];
  pcc_pkg::pix_out_t oldest;
  int       errors;
  int       pixels_sent;
  int       pixels_checked;
  int       reg_writes;
  int       settings_run;

  // Stimulus table for the directed part
  typedef enum {ROW_PIXEL, ROW_WRITE} row_kind_t;
  typedef struct {
    row_kind_t         kind;
    logic [2:0]        idx;
    logic [15:0]       data;
    pcc_pkg::pix_in_t  pix;
    bit                known;
    pcc_pkg::pix_out_t want;
  } row_t;
  row_t directed[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("[pixel_color_correction] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  // Round half up: add half an LSB, then arithmetic shift (floor)
  function automatic longint round_q(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic logic [7:0] clamp_byte(longint v);
    longint q;
    q = round_q(v, PIX_FRAC);
    if (q < 0) begin
      return 8'd0;
    end else if (q > 255) begin
      return 8'd255;
    end
    return q[7:0];
  endfunction

  // Gain, black level and gamma blend on one channel; result in Q.6
  function automatic longint level_channel(logic [7:0] x, pcc_pkg::cfg_t c);
    longint lin, mag, gam, w;
    lin = ((longint'(x) * longint'(c.gain) + 32) >>> 6)
          + longint'($signed(c.black_offset)) * 64;
    mag = (lin < 0) ? -lin : lin;
    gam = (mag * mag * GAMMA_Q20 + (longint'(1) <<< 25)) >>> 26;
    w   = longint'(c.gamma_weight);
    return round_q(lin * (4096 - w) + gam * w, COEF_FRAC);
  endfunction

  function automatic pcc_pkg::pix_out_t correct_pixel(pcc_pkg::pix_in_t p,
                                                      pcc_pkg::cfg_t c);
    longint b, g, r, luma, cb, cr, cb_rot, cr_rot, hc, hs;
    pcc_pkg::pix_out_t o;
    b = level_channel(p.blue_in, c);
    g = level_channel(p.green_in, c);
    r = level_channel(p.red_in, c);
    luma = round_q(LUMA_R * r + LUMA_G * g + LUMA_B * b, COEF_FRAC);
    cb   = round_q(CB_SCALE * (b - luma), COEF_FRAC);
    cr   = round_q(CR_SCALE * (r - luma), COEF_FRAC);
    // hue rotation and chroma gain
    hc = longint'($signed(c.chroma_cos));
    hs = longint'($signed(c.chroma_sin));
    cb_rot = round_q(cb * hc + cr * hs, COEF_FRAC);
    cr_rot = round_q(cr * hc - cb * hs, COEF_FRAC);
    o.blue_out  = clamp_byte(luma + round_q(B_OF_CB * cb_rot, COEF_FRAC));
    o.green_out = clamp_byte(luma - round_q(G_OF_CB * cb_rot + G_OF_CR * cr_rot,
                                            COEF_FRAC));
    o.red_out   = clamp_byte(luma + round_q(R_OF_CR * cr_rot, COEF_FRAC));
    return o;
  endfunction

  // ---------------------------------------------------------------- drivers
  // Present a pixel and hold it until taken; start is left high
  task automatic send_pixel(input pcc_pkg::pix_in_t p, input bit known,
                            input pcc_pkg::pix_out_t want);
    start <= 1'b1;
    pixel <= p;
    do @(posedge clk); while (busy !== 1'b0);
    corrected_q.push_back(known ? want : correct_pixel(p, cfg_shadow));
    pixels_sent++;
  endtask

  // Write one register; cfg_valid is left high for a following write
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    reg_writes++;
    case (idx)
      pcc_pkg::REG_GAIN:         cfg_shadow.gain         = data;
      pcc_pkg::REG_BLACK_OFFSET: cfg_shadow.black_offset = data[10:0];
      pcc_pkg::REG_GAMMA_WEIGHT: cfg_shadow.gamma_weight = data[12:0];
      pcc_pkg::REG_CHROMA_COS:   cfg_shadow.chroma_cos   = data;
      pcc_pkg::REG_CHROMA_SIN:   cfg_shadow.chroma_sin   = data;
      default: ;
    endcase
  endtask

  // Stop feeding pixels and wait for every owed pixel to come out
  task automatic drain();
    start <= 1'b0;
    while (corrected_q.size() != 0) @(posedge clk);
  endtask

  // Random gap after a word; start drops and the pixel bus carries noise
  task automatic idle_gap(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) begin
        pixel <= pcc_pkg::pix_in_t'(24'($urandom));
        @(posedge clk);
      end
    end
  endtask

  // ---------------------------------------------------------------- table rows
  function automatic row_t px(int b, int g, int r);
    row_t t;
    t.kind  = ROW_PIXEL;
    t.idx   = '0;
    t.data  = '0;
    t.pix   = '{blue_in: b[7:0], green_in: g[7:0], red_in: r[7:0]};
    t.known = 1'b0;
    t.want  = '0;
    return t;
  endfunction

  function automatic row_t px_known(int b, int g, int r, int eb, int eg, int er);
    row_t t;
    t = px(b, g, r);
    t.known = 1'b1;
    t.want  = '{blue_out: eb[7:0], green_out: eg[7:0], red_out: er[7:0]};
    return t;
  endfunction

  function automatic row_t wr(logic [2:0] idx, logic [15:0] data);
    row_t t;
    t = px(0, 0, 0);
    t.kind = ROW_WRITE;
    t.idx  = idx;
    t.data = data;
    return t;
  endfunction

  // ---------------------------------------------------------------- random picks
  function automatic logic [15:0] pick_reg(pcc_pkg::reg_idx_t r);
    int k;
    logic [15:0] noise;
    logic [15:0] v;
    k = $urandom_range(0, 9);
    noise = 16'($urandom);
    case (r)
      pcc_pkg::REG_GAIN: begin
        if (k == 0) v = 16'd0;
        else if (k == 1) v = 16'hFFFF;
        else if (k < 6) v = 16'($urandom_range(2048, 6144));
        else v = noise;
      end
      pcc_pkg::REG_BLACK_OFFSET: begin
        // upper bits are don't-care but get toggled
        if (k == 0) v = {noise[15:11], 11'h400};
        else if (k == 1) v = {noise[15:11], 11'h3FF};
        else if (k < 6) v = {noise[15:11], 11'($urandom_range(0, 200) - 100)};
        else v = noise;
      end
      pcc_pkg::REG_GAMMA_WEIGHT: begin
        if (k == 0) v = {noise[15:13], 13'd0};
        else if (k == 1) v = 16'd4096;
        else if (k == 2) v = {noise[15:13], 13'h1FFF};
        else if (k < 6) v = 16'($urandom_range(0, 4096));
        else v = noise;
      end
      default: begin
        // chroma_cos / chroma_sin
        if (k == 0) v = 16'h8000;
        else if (k == 1) v = 16'h7FFF;
        else if (k < 6) v = 16'($urandom_range(0, 16384) - 8192);
        else v = noise;
      end
    endcase
    return v;
  endfunction

  function automatic pcc_pkg::pix_in_t pick_pixel();
    int k;
    logic [7:0] grey;
    pcc_pkg::pix_in_t p;
    k = $urandom_range(0, 9);
    p = pcc_pkg::pix_in_t'(24'($urandom));
    grey = 8'($urandom);
    if (k == 0) begin
      p = '{blue_in: grey, green_in: grey, red_in: grey};
    end else if (k == 1) begin
      p.blue_in  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      p.green_in = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      p.red_in   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end
    return p;
  endfunction

  // ---------------------------------------------------------------- checker
  // A corrected word must match the oldest owed pixel
  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1) begin
      if (corrected_q.size() == 0) begin
        $error("corrected pixel with none owed: %h", result);
        errors++;
      end else begin
        oldest = corrected_q.pop_front();
        pixels_checked++;
        if (result.blue_out !== oldest.blue_out) begin
          $error("blue_out: expected %0d, got %0d", oldest.blue_out, result.blue_out);
          errors++;
        end
        if (result.green_out !== oldest.green_out) begin
          $error("green_out: expected %0d, got %0d", oldest.green_out, result.green_out);
          errors++;
        end
        if (result.red_out !== oldest.red_out) begin
          $error("red_out: expected %0d, got %0d", oldest.red_out, result.red_out);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  initial begin
    int burst;
    int roll;
    int gap;
    pcc_pkg::pix_in_t p;
    pcc_pkg::reg_idx_t ri;

    errors = 0;
    pixels_sent = 0;
    pixels_checked = 0;
    reg_writes = 0;
    settings_run = 1;
    cfg_shadow = pcc_pkg::CFG_RESET;
    rst       <= 1'b1;
    start     <= 1'b0;
    pixel     <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings pass grey unchanged, then each register at its extremes
    directed.push_back(px_known(0, 0, 0, 0, 0, 0));
    directed.push_back(px_known(255, 255, 255, 255, 255, 255));
    directed.push_back(px_known(128, 128, 128, 128, 128, 128));
    directed.push_back(px(255, 0, 0));
    directed.push_back(px(0, 255, 0));
    directed.push_back(px(0, 0, 255));
    directed.push_back(px(85, 170, 51));
    directed.push_back(wr(pcc_pkg::REG_BLACK_OFFSET, 16'h0400));
    directed.push_back(px_known(255, 255, 255, 0, 0, 0));
    directed.push_back(wr(pcc_pkg::REG_BLACK_OFFSET, 16'h03FF));
    directed.push_back(px_known(0, 0, 0, 255, 255, 255));
    directed.push_back(wr(pcc_pkg::REG_BLACK_OFFSET, 16'h0000));
    directed.push_back(wr(pcc_pkg::REG_GAIN, 16'hFFFF));
    directed.push_back(px_known(1, 1, 1, 16, 16, 16));
    directed.push_back(px(200, 10, 90));
    directed.push_back(wr(pcc_pkg::REG_GAIN, 16'h0000));
    directed.push_back(px_known(17, 200, 255, 0, 0, 0));
    directed.push_back(wr(pcc_pkg::REG_GAIN, 16'd4096));
    directed.push_back(wr(pcc_pkg::REG_GAMMA_WEIGHT, 16'd4096));
    directed.push_back(px(255, 255, 255));
    directed.push_back(px(100, 150, 200));
    // gamma weight above one: the linear term goes negative
    directed.push_back(wr(pcc_pkg::REG_GAMMA_WEIGHT, 16'h1FFF));
    directed.push_back(px(255, 255, 255));
    directed.push_back(px(30, 60, 90));
    directed.push_back(wr(pcc_pkg::REG_GAMMA_WEIGHT, 16'd0));
    directed.push_back(wr(pcc_pkg::REG_CHROMA_COS, 16'h8000));
    directed.push_back(wr(pcc_pkg::REG_CHROMA_SIN, 16'h7FFF));
    directed.push_back(px(255, 0, 0));
    directed.push_back(px(0, 0, 255));
    directed.push_back(wr(pcc_pkg::REG_CHROMA_COS, 16'h7FFF));
    directed.push_back(wr(pcc_pkg::REG_CHROMA_SIN, 16'h8000));
    directed.push_back(px(0, 255, 0));
    directed.push_back(px(40, 220, 130));
    directed.push_back(wr(pcc_pkg::REG_CHROMA_COS, 16'h0000));
    directed.push_back(wr(pcc_pkg::REG_CHROMA_SIN, 16'h0000));
    directed.push_back(px(10, 100, 250));
    // writes past the register map must change nothing
    directed.push_back(wr(IDX_SPARE_LO, 16'h1234));
    directed.push_back(wr(IDX_SPARE_HI, 16'hFFFF));
    directed.push_back(px(10, 100, 250));

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_WRITE) begin
        if (i == 0 || directed[i-1].kind != ROW_WRITE) begin
          drain();
          settings_run++;
        end
        write_reg(directed[i].idx, directed[i].data);
      end else begin
        cfg_valid <= 1'b0;
        send_pixel(directed[i].pix, directed[i].known, directed[i].want);
      end
    end

    // Random: a fresh register setting per phase, then a pixel stream with gaps
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      settings_run++;
      for (int j = 0; j < 5; j++) begin
        ri = pcc_pkg::reg_idx_t'(j);
        write_reg(ri, pick_reg(ri));
      end
      if ($urandom_range(0, 2) == 0) begin
        write_reg(3'($urandom_range(IDX_SPARE_LO, IDX_SPARE_HI)), 16'($urandom));
      end
      cfg_valid <= 1'b0;
      burst = ($urandom_range(0, 2) == 0);
      for (int n = 0; n < PIX_PER_PHASE; n++) begin
        p = pick_pixel();
        send_pixel(p, 1'b0, '0);
        roll = $urandom_range(0, 99);
        if (burst || roll < 60) gap = 0;
        else if (roll < 90) gap = $urandom_range(1, 3);
        else gap = $urandom_range(4, 40);
        idle_gap(gap);
      end
    end

    drain();
    repeat (pcc_pkg::LATENCY + 4) @(posedge clk);
    $display("Checked %0d of %0d pixels over %0d register settings (%0d writes).",
             pixels_checked, pixels_sent, settings_run, reg_writes);
    $display("Field mismatches or stray words: %0d.", errors);
    if (errors == 0) begin
      $display("[pixel_color_correction] OK");
    end else begin
      $display("[pixel_color_correction] ERROR");
    end
    $finish;
  end

endmodule
